// ===== rtl/core/tia_pkg.sv =====
// shared types, constants and tables of the turbo interleaver address block
// no dependencies
package tia_pkg;

  // field and datapath widths
  localparam int PosW     = 14;
  localparam int BaseW    = 8;
  localparam int OctetW   = 4;
  localparam int K2W      = BaseW + OctetW;
  localparam int RemW     = 18;
  localparam int PrimeW   = 7;
  localparam int QuotBits = 7;
  localparam int CfgIdxW  = 4;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgBaseSize   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgOctetCount = CfgIdxW'(1);

  // reset values of the configuration registers
  localparam logic [BaseW-1:0]  BaseReset  = BaseW'(223);
  localparam logic [OctetW-1:0] OctetReset = OctetW'(1);

  // offset added for odd positions
  localparam logic [RemW-1:0] OddOffset = RemW'(21);

  // word after the row decode
  typedef struct packed {
    logic [K2W-1:0] col;
    logic [1:0]     row;
    logic           odd;
    logic           inr;
  } dec_t;

  // word carried along the modulo chain
  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [1:0]      row;
    logic            odd;
    logic            inr;
  } cell_t;

  // prime table, indexed by q = t mod 8
  function automatic logic [PrimeW-1:0] prime_of(input logic [2:0] q);
    logic [PrimeW-1:0] p;
    unique case (q)
      3'd0:    p = PrimeW'(31);
      3'd1:    p = PrimeW'(37);
      3'd2:    p = PrimeW'(43);
      3'd3:    p = PrimeW'(47);
      3'd4:    p = PrimeW'(53);
      3'd5:    p = PrimeW'(59);
      3'd6:    p = PrimeW'(61);
      default: p = PrimeW'(67);
    endcase
    return p;
  endfunction

  // t = (19*i + 1) mod 4 for block row i
  function automatic logic [1:0] row_of(input logic [1:0] i);
    logic [1:0] t;
    unique case (i)
      2'd0:    t = 2'd1;
      2'd1:    t = 2'd0;
      2'd2:    t = 2'd3;
      default: t = 2'd2;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/core/tia_decode.sv =====
// first cell: range check, block row and column of the position
// depends on tia_pkg
module tia_decode (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [tia_pkg::K2W-1:0]  k2_i,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [tia_pkg::PosW-1:0] pos_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output tia_pkg::dec_t          data_o
);
  import tia_pkg::*;

  logic [PosW-2:0] half_pos;
  logic [PosW:0]   k2x8;
  logic [PosW-2:0] k2x2;
  logic [PosW-1:0] k2x3;
  logic [PosW-1:0] sub;
  logic [PosW-1:0] col_w;
  logic [1:0]      blk;
  logic            ge1, ge2, ge3;
  logic            valid_q;
  dec_t            data_d, data_q;

  // multiples of k2 for the block row compare
  always_comb begin
    half_pos = pos_i[PosW-1:1];
    k2x8     = {k2_i, 3'b000};
    k2x2     = {k2_i, 1'b0};
    k2x3     = PosW'({k2_i, 1'b0}) + PosW'(k2_i);
    ge1      = PosW'(half_pos) >= PosW'(k2_i);
    ge2      = half_pos >= k2x2;
    ge3      = PosW'(half_pos) >= k2x3;
  end

  // block row and column inside it
  always_comb begin
    priority if (ge3) begin
      blk = 2'd3;
      sub = k2x3;
    end else if (ge2) begin
      blk = 2'd2;
      sub = PosW'(k2x2);
    end else if (ge1) begin
      blk = 2'd1;
      sub = PosW'(k2_i);
    end else begin
      blk = 2'd0;
      sub = '0;
    end
    col_w       = PosW'(half_pos) - sub;
    data_d.col  = col_w[K2W-1:0];
    data_d.row  = row_of(blk);
    data_d.odd  = pos_i[0];
    data_d.inr  = (PosW + 1)'(pos_i) < k2x8;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/tia_scale.sv =====
// second cell: column times the row prime plus the odd offset
// depends on tia_pkg
module tia_scale (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  tia_pkg::dec_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output tia_pkg::cell_t data_o
);
  import tia_pkg::*;

  localparam int ProdW = PrimeW + K2W;

  logic [PrimeW-1:0] prime;
  logic [ProdW-1:0]  prod;
  logic              valid_q;
  cell_t             data_d, data_q;

  // p[q] * j + 21 * m
  always_comb begin
    prime       = prime_of({1'b0, data_i.row});
    prod        = ProdW'(prime) * ProdW'(data_i.col);
    data_d.rem  = prod[RemW-1:0] + (data_i.odd ? OddOffset : '0);
    data_d.row  = data_i.row;
    data_d.odd  = data_i.odd;
    data_d.inr  = data_i.inr;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/tia_mod_cell.sv =====
// one restoring step of the modulo by k2: subtract k2 << SHIFT if it fits
// depends on tia_pkg
module tia_mod_cell #(
  parameter int SHIFT = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [tia_pkg::K2W-1:0] k2_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  tia_pkg::cell_t        data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output tia_pkg::cell_t        data_o
);
  import tia_pkg::*;

  localparam int CmpW = RemW + 1;

  logic [CmpW-1:0] divisor;
  logic [CmpW-1:0] diff;
  logic            valid_q;
  cell_t           data_d, data_q;

  // conditional subtract of the shifted divisor
  always_comb begin
    divisor = CmpW'(k2_i) << SHIFT;
    diff    = CmpW'(data_i.rem) - divisor;
    data_d  = data_i;
    if (CmpW'(data_i.rem) >= divisor) begin
      data_d.rem = diff[RemW-1:0];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/turbo_interleaver_address_top.sv =====
// top level of the turbo interleaver address generator
// depends on tia_pkg, tia_decode, tia_scale, tia_mod_cell
//
// usage:
// - input channel: in_valid_i with position_i, in_stall_o back; a word is
//   taken at a clock edge with in_valid_i high and in_stall_o low
// - output channel: out_valid_o with permuted_position_o and in_range_o,
//   out_stall_i from the receiver; a word leaves at an edge with
//   out_valid_o high and out_stall_i low
// - configuration: cfg_valid_i, cfg_index_i, cfg_data_i, cfg_ready_o is
//   always high; index 0 is base_size, index 1 octet_count, other
//   indexes are ignored; write only while the pipeline is empty
// - the pipeline has nine register stages: row decode, prime multiply and
//   seven cells of a restoring modulo by k2, each cell a register stage
// - throughput is one word per cycle; every stage holds its word only
//   while the stage after it is full and stalled
// - a stalled receiver fills the chain stage by stage; in_stall_o rises
//   once all nine stages hold a word
// - out-of-range positions travel the chain and come out as 0 with
//   in_range_o low
// - reset empties the chain and sets base_size 223, octet_count 1
module turbo_interleaver_address_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tia_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tia_pkg::BaseW-1:0]  cfg_data_i,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [tia_pkg::PosW-1:0]   position_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tia_pkg::PosW-1:0]   permuted_position_o,
  output logic                       in_range_o
);
  import tia_pkg::*;

  logic [BaseW-1:0]  base_q;
  logic [OctetW-1:0] octet_q;
  logic [K2W-1:0]    k2;

  logic              dec_valid, dec_ready, in_ready;
  dec_t              dec_data;

  logic              chain_valid [QuotBits+1];
  logic              chain_ready [QuotBits+1];
  cell_t             chain_data  [QuotBits+1];

  cell_t             last;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BaseReset;
      octet_q <= OctetReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgBaseSize) begin
        base_q <= cfg_data_i;
      end
      if (cfg_index_i == CfgOctetCount) begin
        octet_q <= cfg_data_i[OctetW-1:0];
      end
    end
  end

  // interleaver dimension k2
  assign k2 = K2W'(base_q) * K2W'(octet_q);

  // row decode
  tia_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .k2_i    (k2),
    .valid_i (in_valid_i),
    .ready_o (in_ready),
    .pos_i   (position_i),
    .valid_o (dec_valid),
    .ready_i (dec_ready),
    .data_o  (dec_data)
  );

  assign in_stall_o = !in_ready;

  // prime multiply
  tia_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .data_i  (dec_data),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .data_o  (chain_data[0])
  );

  // modulo chain, largest shift first
  for (genvar g = 0; g < QuotBits; g++) begin : g_mod
    tia_mod_cell #(
      .SHIFT (QuotBits - 1 - g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .k2_i    (k2),
      .valid_i (chain_valid[g]),
      .ready_o (chain_ready[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .ready_i (chain_ready[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  // result word: r = 8c + 2t + 1 - m
  assign last                = chain_data[QuotBits];
  assign chain_ready[QuotBits] = !out_stall_i;
  assign out_valid_o         = chain_valid[QuotBits];
  assign in_range_o          = last.inr;
  assign permuted_position_o = last.inr ?
                               {last.rem[PosW-4:0], last.row, !last.odd} : '0;

  // an empty output register means the whole chain can take a word
  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output stage is empty");

  // the remainder has been fully reduced
  a_rem_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && in_range_o) |-> (last.rem < RemW'(k2)))
    else $error("remainder not below k2");

  // a decoded column lies inside its block row
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dec_valid && dec_data.inr) |-> (dec_data.col < k2))
    else $error("column outside the block row");

  // nothing is in range while the dimension is zero
  a_zero_dim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dec_valid && k2 == '0) |-> !dec_data.inr)
    else $error("in-range word with zero dimension");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of turbo_interleaver_address_top: interleaved addresses
// are predicted in the bench and compared word by word; depends on tia_pkg
`timescale 1ns / 1ps

module testbench;
  import tia_pkg::*;

  localparam int unsigned RowsK1        = 8;
  localparam int unsigned RowStep       = 19;
  localparam int unsigned OddShift      = 21;
  localparam int unsigned PosSpan       = 1 << PosW;
  localparam int          PipeDepth     = 9;
  localparam int          DrainCycles   = PipeDepth + 3;
  localparam int          HoldCycles    = 150;
  localparam int          WatchdogLimit = 1000;
  localparam int          RandomPhases  = 13;
  localparam int          PhaseItems    = 120;
  localparam logic [CfgIdxW-1:0] CfgFirstUnused = CfgIdxW'(2);

  // one result word of the block
  typedef struct packed {
    logic [PosW-1:0] pos;
    logic            inr;
  } addr_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [BaseW-1:0]    cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [PosW-1:0]     position_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [PosW-1:0]     permuted_position_o;
  logic                in_range_o;

  // shadow copy of the dimension registers
  logic [BaseW-1:0]    shadow_base;
  logic [OctetW-1:0]   shadow_octet;

  addr_word_t pending_addrs[$];

  bit tx_idle_on    = 1'b1;
  bit rx_idle_on    = 1'b1;
  bit long_hold_req = 1'b0;

  int mismatch_count     = 0;
  int words_checked      = 0;
  int words_out_of_range = 0;
  int settings_used      = 1;
  int input_stall_cycles = 0;

  turbo_interleaver_address_top u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .position_i          (position_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .permuted_position_o (permuted_position_o),
    .in_range_o          (in_range_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // interleaver permutation for the current register setting
  function automatic addr_word_t interleave_addr(input logic [PosW-1:0] pos);
    int unsigned k2, n, m, i, j, t, prime, c, r;
    addr_word_t w;
    k2 = int'(shadow_base) * int'(shadow_octet);
    n = pos;
    w.pos = '0;
    w.inr = 1'b0;
    if (k2 != 0 && n < RowsK1 * k2) begin
      m = n & 1;
      i = n / (2 * k2);
      j = (n >> 1) - i * k2;
      t = (RowStep * i + 1) % (RowsK1 / 2);
      case (t % 8)
        0:       prime = 31;
        1:       prime = 37;
        2:       prime = 43;
        3:       prime = 47;
        4:       prime = 53;
        5:       prime = 59;
        6:       prime = 61;
        default: prime = 67;
      endcase
      c = (prime * j + OddShift * m) % k2;
      r = 2 * (t + c * (RowsK1 / 2) + 1) - m - 1;
      w.pos = r[PosW-1:0];
      w.inr = 1'b1;
    end
    return w;
  endfunction

  // offer one position word, with an optional idle burst ahead of it
  task automatic offer_position(input logic [PosW-1:0] pos);
    @(negedge clk_i);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    position_i = pos;
    do @(posedge clk_i); while (in_stall_o);
    pending_addrs.push_back(interleave_addr(pos));
  endtask

  // stop offering and wait until every expected word has come out
  task automatic wait_until_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_addrs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // one register write, shadow updated at the handshake
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [BaseW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgBaseSize) begin
      shadow_base = data;
    end else if (idx == CfgOctetCount) begin
      shadow_octet = data[OctetW-1:0];
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_dimensions(input logic [BaseW-1:0] base, input logic [BaseW-1:0] octet);
    wait_until_drained();
    write_register(CfgBaseSize, base);
    write_register(CfgOctetCount, octet);
    settings_used++;
  endtask

  // reset setting: row edges, last valid position, first invalid one, bit patterns
  task automatic test_default_setting();
    offer_position(14'd0);
    offer_position(14'd1);
    offer_position(14'd445);
    offer_position(14'd446);
    offer_position(14'd447);
    offer_position(14'd1782);
    offer_position(14'd1783);
    offer_position(14'd1784);
    offer_position(14'h3FFF);
    offer_position(14'h2AAA);
    offer_position(14'h1555);
  endtask

  // register extremes, oversized dimension, zero dimension, unused indexes
  task automatic test_register_extremes();
    set_dimensions(8'd255, 8'd8);
    offer_position(14'd16319);
    offer_position(14'd16320);
    offer_position(14'h3FFF);
    // octet count 15 from a write with the upper data bits set
    wait_until_drained();
    write_register(CfgOctetCount, 8'hFF);
    offer_position(14'h3FFF);
    offer_position(14'h3FFE);
    offer_position(14'd9000);
    // smallest dimension, upper data bits of the octet write ignored
    set_dimensions(8'd1, 8'hF1);
    offer_position(14'd0);
    offer_position(14'd7);
    offer_position(14'd8);
    // writes to indexes with no register must change nothing
    wait_until_drained();
    write_register(CfgIdxW'(8), 8'd0);
    write_register(CfgIdxW'(9), 8'd0);
    write_register({CfgIdxW{1'b1}}, 8'd0);
    offer_position(14'd5);
    // zero base size, then zero octet count
    set_dimensions(8'd0, 8'd1);
    offer_position(14'd0);
    set_dimensions(8'd200, 8'd0);
    offer_position(14'd0);
  endtask

  // random settings, each followed by a batch of positions
  task automatic test_random_settings();
    int unsigned base_v, octet_v, span, sel;
    logic [PosW-1:0] pos;
    for (int ph = 0; ph < RandomPhases; ph++) begin
      if (ph == 0) begin
        base_v  = 255;
        octet_v = 15;
      end else if (ph == 1) begin
        base_v  = 1;
        octet_v = 1;
      end else begin
        base_v  = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 255);
        sel     = $urandom_range(0, 19);
        octet_v = (sel == 0) ? 0 : (sel < 4) ? $urandom_range(9, 15) : $urandom_range(1, 8);
      end
      if ($urandom_range(0, 3) == 0) begin
        wait_until_drained();
        write_register(CfgIdxW'($urandom_range((1 << CfgIdxW) - 1, CfgFirstUnused)),
                       BaseW'($urandom));
      end
      set_dimensions(base_v[BaseW-1:0], {4'($urandom_range(0, 15)), octet_v[3:0]});
      span = RowsK1 * base_v * octet_v;
      repeat (PhaseItems) begin
        sel = $urandom_range(0, 9);
        if (sel <= 5 && span != 0) begin
          pos = PosW'($urandom_range(0, ((span > PosSpan) ? PosSpan : span) - 1));
        end else if (sel == 6) begin
          pos = PosW'(span + $urandom_range(0, 3) - 2);
        end else begin
          pos = PosW'($urandom_range(0, PosSpan - 1));
        end
        offer_position(pos);
      end
    end
  endtask

  // receiver holds off for a long stretch while positions keep coming
  task automatic test_output_backpressure();
    set_dimensions(8'd223, 8'd4);
    tx_idle_on = 1'b0;
    @(negedge clk_i);
    long_hold_req = 1'b1;
    repeat (60) offer_position(PosW'($urandom_range(0, 7135)));
    tx_idle_on = 1'b1;
  endtask

  // closing stretch with no idling on either side
  task automatic test_steady_stream();
    set_dimensions(8'd223, 8'd8);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (150) offer_position(PosW'($urandom_range(0, PosSpan - 1)));
  endtask

  // receiver: random stall bursts and the long hold-off on request
  initial begin : receiver
    int hold_left;
    int burst_left;
    hold_left   = 0;
    burst_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i = 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall_i = 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        burst_left  = $urandom_range(0, 4);
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // compare each word leaving the block with the oldest expectation
  always @(posedge clk_i) begin : addr_check
    addr_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_addrs.size() == 0) begin
        mismatch_count++;
        $display("[%0t] unexpected word: expected none, actual pos %0d in_range %0b",
                 $time, permuted_position_o, in_range_o);
      end else begin
        want = pending_addrs.pop_front();
        words_checked++;
        if (!want.inr) words_out_of_range++;
        if (permuted_position_o !== want.pos) begin
          mismatch_count++;
          $display("[%0t] permuted_position mismatch: expected %0d, actual %0d",
                   $time, want.pos, permuted_position_o);
        end
        if (in_range_o !== want.inr) begin
          mismatch_count++;
          $display("[%0t] in_range mismatch: expected %0b, actual %0b",
                   $time, want.inr, in_range_o);
        end
      end
    end
    if (rst_ni && in_valid_i && in_stall_o) input_stall_cycles++;
  end

  // watchdog: ends the run after too many cycles with no handshake
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o) || !rst_ni)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[%0t] watchdog: no handshake for %0d cycles, %0d words still expected",
             $time, WatchdogLimit, pending_addrs.size());
    $display("testbench: done, errors");
    $finish;
  end

  // main sequence
  initial begin
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    position_i   = '0;
    shadow_base  = BaseReset;
    shadow_octet = OctetReset;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_setting();
    test_register_extremes();
    test_random_settings();
    test_output_backpressure();
    test_steady_stream();
    wait_until_drained();

    $display("summary: %0d addresses checked, %0d of them out of range, over %0d settings",
             words_checked, words_out_of_range, settings_used);
    $display("summary: input held off for %0d cycles by output back-pressure",
             input_stall_cycles);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tia_pkg.sv
rtl/core/tia_decode.sv
rtl/core/tia_scale.sv
rtl/core/tia_mod_cell.sv
rtl/core/turbo_interleaver_address_top.sv
tb/testbench.sv
